/* rtl/core/rvdec_pkg.sv */
// Shared types, operation codes and decode tables for the RV32I instruction decoder.
package rvdec_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned OpWidth   = 6;
  localparam int unsigned RegWidth  = 5;

  localparam logic [WordWidth-1:0] HALT_WORD  = 32'h0ff00513;
  localparam logic [6:0]           OPC_LOAD   = 7'h03;
  localparam logic [6:0]           OPC_OPIMM  = 7'h13;
  localparam logic [6:0]           OPC_AUIPC  = 7'h17;
  localparam logic [6:0]           OPC_STORE  = 7'h23;
  localparam logic [6:0]           OPC_OP     = 7'h33;
  localparam logic [6:0]           OPC_LUI    = 7'h37;
  localparam logic [6:0]           OPC_BRANCH = 7'h63;
  localparam logic [6:0]           OPC_JALR   = 7'h67;
  localparam logic [6:0]           OPC_JAL    = 7'h6f;
  localparam logic [6:0]           F7_BASE    = 7'h00;
  localparam logic [6:0]           F7_ALT     = 7'h20;
  localparam logic [WordWidth-1:0] UPPER_MASK = 32'hfffff000;

  localparam logic [2:0] F3_ZERO = 3'd0;
  localparam logic [2:0] F3_SL   = 3'd1;
  localparam logic [2:0] F3_SR   = 3'd5;

  localparam logic [OpWidth-1:0] OP_INVALID = 6'd0;
  localparam logic [OpWidth-1:0] OP_HALT    = 6'd1;
  localparam logic [OpWidth-1:0] OP_ADD     = 6'd2;
  localparam logic [OpWidth-1:0] OP_SUB     = 6'd3;
  localparam logic [OpWidth-1:0] OP_SLL     = 6'd4;
  localparam logic [OpWidth-1:0] OP_SLT     = 6'd5;
  localparam logic [OpWidth-1:0] OP_SLTU    = 6'd6;
  localparam logic [OpWidth-1:0] OP_XOR     = 6'd7;
  localparam logic [OpWidth-1:0] OP_SRL     = 6'd8;
  localparam logic [OpWidth-1:0] OP_SRA     = 6'd9;
  localparam logic [OpWidth-1:0] OP_OR      = 6'd10;
  localparam logic [OpWidth-1:0] OP_AND     = 6'd11;
  localparam logic [OpWidth-1:0] OP_ADDI    = 6'd12;
  localparam logic [OpWidth-1:0] OP_SLLI    = 6'd13;
  localparam logic [OpWidth-1:0] OP_SLTI    = 6'd14;
  localparam logic [OpWidth-1:0] OP_SLTIU   = 6'd15;
  localparam logic [OpWidth-1:0] OP_XORI    = 6'd16;
  localparam logic [OpWidth-1:0] OP_SRLI    = 6'd17;
  localparam logic [OpWidth-1:0] OP_SRAI    = 6'd18;
  localparam logic [OpWidth-1:0] OP_ORI     = 6'd19;
  localparam logic [OpWidth-1:0] OP_ANDI    = 6'd20;
  localparam logic [OpWidth-1:0] OP_LB      = 6'd21;
  localparam logic [OpWidth-1:0] OP_LH      = 6'd22;
  localparam logic [OpWidth-1:0] OP_LW      = 6'd23;
  localparam logic [OpWidth-1:0] OP_LBU     = 6'd24;
  localparam logic [OpWidth-1:0] OP_LHU     = 6'd25;
  localparam logic [OpWidth-1:0] OP_SB      = 6'd26;
  localparam logic [OpWidth-1:0] OP_SH      = 6'd27;
  localparam logic [OpWidth-1:0] OP_SW      = 6'd28;
  localparam logic [OpWidth-1:0] OP_BEQ     = 6'd29;
  localparam logic [OpWidth-1:0] OP_BNE     = 6'd30;
  localparam logic [OpWidth-1:0] OP_BLT     = 6'd31;
  localparam logic [OpWidth-1:0] OP_BGE     = 6'd32;
  localparam logic [OpWidth-1:0] OP_BLTU    = 6'd33;
  localparam logic [OpWidth-1:0] OP_BGEU    = 6'd34;
  localparam logic [OpWidth-1:0] OP_JAL     = 6'd35;
  localparam logic [OpWidth-1:0] OP_JALR    = 6'd36;
  localparam logic [OpWidth-1:0] OP_LUI     = 6'd37;
  localparam logic [OpWidth-1:0] OP_AUIPC   = 6'd38;

  localparam logic [1:0] SRC_REG  = 2'd0;
  localparam logic [1:0] SRC_PC   = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;

  localparam logic [2:0] CLS_OTHER  = 3'd0;
  localparam logic [2:0] CLS_LOAD   = 3'd1;
  localparam logic [2:0] CLS_STORE  = 3'd2;
  localparam logic [2:0] CLS_BRANCH = 3'd3;
  localparam logic [2:0] CLS_JUMP   = 3'd4;

  typedef struct packed {
    logic [OpWidth-1:0]   operation;
    logic [RegWidth-1:0]  dest_reg;
    logic [RegWidth-1:0]  src1_reg;
    logic [RegWidth-1:0]  src2_reg;
    logic [WordWidth-1:0] imm_value;
    logic [1:0]           left_source;
    logic                 right_source;
    logic                 reads_src1;
    logic                 reads_src2;
    logic                 writes_dest;
    logic [2:0]           insn_class;
  } decode_t;

  // Register-register operation for funct7 all zero.
  function automatic logic [OpWidth-1:0] reg_op(input logic [2:0] f3);
    logic [OpWidth-1:0] op;
    case (f3)
      3'd0:    op = OP_ADD;
      3'd1:    op = OP_SLL;
      3'd2:    op = OP_SLT;
      3'd3:    op = OP_SLTU;
      3'd4:    op = OP_XOR;
      3'd5:    op = OP_SRL;
      3'd6:    op = OP_OR;
      default: op = OP_AND;
    endcase
    return op;
  endfunction

  // Register-immediate operation for the funct3 codes that are not shifts.
  function automatic logic [OpWidth-1:0] imm_op(input logic [2:0] f3);
    logic [OpWidth-1:0] op;
    case (f3)
      3'd0:    op = OP_ADDI;
      3'd2:    op = OP_SLTI;
      3'd3:    op = OP_SLTIU;
      3'd4:    op = OP_XORI;
      3'd6:    op = OP_ORI;
      3'd7:    op = OP_ANDI;
      default: op = OP_INVALID;
    endcase
    return op;
  endfunction

  function automatic logic [OpWidth-1:0] load_op(input logic [2:0] f3);
    logic [OpWidth-1:0] op;
    case (f3)
      3'd0:    op = OP_LB;
      3'd1:    op = OP_LH;
      3'd2:    op = OP_LW;
      3'd4:    op = OP_LBU;
      3'd5:    op = OP_LHU;
      default: op = OP_INVALID;
    endcase
    return op;
  endfunction

  function automatic logic [OpWidth-1:0] store_op(input logic [2:0] f3);
    logic [OpWidth-1:0] op;
    case (f3)
      3'd0:    op = OP_SB;
      3'd1:    op = OP_SH;
      3'd2:    op = OP_SW;
      default: op = OP_INVALID;
    endcase
    return op;
  endfunction

  function automatic logic [OpWidth-1:0] branch_op(input logic [2:0] f3);
    logic [OpWidth-1:0] op;
    case (f3)
      3'd0:    op = OP_BEQ;
      3'd1:    op = OP_BNE;
      3'd4:    op = OP_BLT;
      3'd5:    op = OP_BGE;
      3'd6:    op = OP_BLTU;
      3'd7:    op = OP_BGEU;
      default: op = OP_INVALID;
    endcase
    return op;
  endfunction

endpackage

/* rtl/core/rvdec_decode.sv */
// Combinational field extraction and decode of one RV32I instruction word.
module rvdec_decode (
  input  logic [rvdec_pkg::WordWidth-1:0] instruction,
  output rvdec_pkg::decode_t              dec
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rd;
  logic [4:0] rs1;
  logic [4:0] rs2;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;

  assign opc = instruction[6:0];
  assign f3  = instruction[14:12];
  assign f7  = instruction[31:25];
  assign rd  = instruction[11:7];
  assign rs1 = instruction[19:15];
  assign rs2 = instruction[24:20];

  assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
  assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
  assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                  instruction[30:25], instruction[11:8], 1'b0};
  assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                  instruction[20], instruction[30:21], 1'b0};

  always_comb begin
    dec = '0;
    if (instruction == rvdec_pkg::HALT_WORD) begin
      dec.operation = rvdec_pkg::OP_HALT;
    end else begin
      case (opc)
        rvdec_pkg::OPC_OP: begin
          if (f7 == rvdec_pkg::F7_BASE) begin
            dec.operation = rvdec_pkg::reg_op(f3);
          end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_ZERO) begin
            dec.operation = rvdec_pkg::OP_SUB;
          end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_SR) begin
            dec.operation = rvdec_pkg::OP_SRA;
          end
          if (dec.operation != rvdec_pkg::OP_INVALID) begin
            dec.dest_reg   = rd;
            dec.src1_reg   = rs1;
            dec.src2_reg   = rs2;
            dec.reads_src1 = 1'b1;
            dec.reads_src2 = 1'b1;
          end
        end
        rvdec_pkg::OPC_OPIMM: begin
          if (f3 == rvdec_pkg::F3_SL) begin
            if (f7 == rvdec_pkg::F7_BASE) begin
              dec.operation = rvdec_pkg::OP_SLLI;
            end
          end else if (f3 == rvdec_pkg::F3_SR) begin
            if (f7 == rvdec_pkg::F7_BASE) begin
              dec.operation = rvdec_pkg::OP_SRLI;
            end else if (f7 == rvdec_pkg::F7_ALT) begin
              dec.operation = rvdec_pkg::OP_SRAI;
            end
          end else begin
            dec.operation = rvdec_pkg::imm_op(f3);
          end
          if (dec.operation != rvdec_pkg::OP_INVALID) begin
            dec.dest_reg     = rd;
            dec.src1_reg     = rs1;
            // Shifts carry the shift amount, zero-extended, in place of the immediate.
            dec.imm_value    = (f3 == rvdec_pkg::F3_SL || f3 == rvdec_pkg::F3_SR) ?
                               {27'd0, rs2} : imm_i;
            dec.right_source = 1'b1;
            dec.reads_src1   = 1'b1;
          end
        end
        rvdec_pkg::OPC_LOAD: begin
          dec.operation = rvdec_pkg::load_op(f3);
          if (dec.operation != rvdec_pkg::OP_INVALID) begin
            dec.dest_reg     = rd;
            dec.src1_reg     = rs1;
            dec.imm_value    = imm_i;
            dec.right_source = 1'b1;
            dec.reads_src1   = 1'b1;
            dec.insn_class   = rvdec_pkg::CLS_LOAD;
          end
        end
        rvdec_pkg::OPC_JALR: begin
          if (f3 == rvdec_pkg::F3_ZERO) begin
            dec.operation    = rvdec_pkg::OP_JALR;
            dec.dest_reg     = rd;
            dec.src1_reg     = rs1;
            dec.imm_value    = imm_i;
            dec.right_source = 1'b1;
            dec.reads_src1   = 1'b1;
            dec.insn_class   = rvdec_pkg::CLS_JUMP;
          end
        end
        rvdec_pkg::OPC_STORE: begin
          dec.operation = rvdec_pkg::store_op(f3);
          if (dec.operation != rvdec_pkg::OP_INVALID) begin
            dec.src1_reg     = rs1;
            dec.src2_reg     = rs2;
            dec.imm_value    = imm_s;
            dec.right_source = 1'b1;
            dec.reads_src1   = 1'b1;
            dec.reads_src2   = 1'b1;
            dec.insn_class   = rvdec_pkg::CLS_STORE;
          end
        end
        rvdec_pkg::OPC_BRANCH: begin
          dec.operation = rvdec_pkg::branch_op(f3);
          if (dec.operation != rvdec_pkg::OP_INVALID) begin
            dec.src1_reg   = rs1;
            dec.src2_reg   = rs2;
            dec.imm_value  = imm_b;
            dec.reads_src1 = 1'b1;
            dec.reads_src2 = 1'b1;
            dec.insn_class = rvdec_pkg::CLS_BRANCH;
          end
        end
        rvdec_pkg::OPC_JAL: begin
          dec.operation    = rvdec_pkg::OP_JAL;
          dec.dest_reg     = rd;
          dec.imm_value    = imm_j;
          dec.left_source  = rvdec_pkg::SRC_PC;
          dec.right_source = 1'b1;
          dec.insn_class   = rvdec_pkg::CLS_JUMP;
        end
        rvdec_pkg::OPC_LUI: begin
          dec.operation    = rvdec_pkg::OP_LUI;
          dec.dest_reg     = rd;
          dec.imm_value    = instruction & rvdec_pkg::UPPER_MASK;
          dec.left_source  = rvdec_pkg::SRC_ZERO;
          dec.right_source = 1'b1;
        end
        rvdec_pkg::OPC_AUIPC: begin
          dec.operation    = rvdec_pkg::OP_AUIPC;
          dec.dest_reg     = rd;
          dec.imm_value    = instruction & rvdec_pkg::UPPER_MASK;
          dec.left_source  = rvdec_pkg::SRC_PC;
          dec.right_source = 1'b1;
        end
        default: begin
          dec = '0;
        end
      endcase
    end
    dec.writes_dest = (dec.operation != rvdec_pkg::OP_INVALID) &&
                      (dec.operation != rvdec_pkg::OP_HALT) &&
                      (dec.dest_reg != '0);
  end

endmodule

/* rtl/core/rv32i_instruction_decoder.sv */
// Top level of the RV32I instruction decoder: input register, decode logic, result register.
//
// The decoder takes one 32-bit RV32I instruction word per item and returns one decoded
// result per item. An item is accepted at a rising clock edge where start is high and busy
// is low; busy is always low, so a new word may be given in every cycle. The word is
// captured in an input register, decoded by a single combinational pass, and the result is
// captured in a result register, so the result for an accepted word passes the input
// register and then the result register before it appears on the result ports, with done
// high for a single cycle. The receiver cannot stall the block, so it must
// take every result in the cycle that done marks it. Throughput is one item per cycle,
// set by the single decode pass between the two registers. Unknown encodings return the
// INVALID operation with every other field zero, and the word 0x0ff00513 returns HALT
// with every other field zero. writes_dest is low whenever the destination is register
// zero. The block holds no other state; reset clears only the two valid flags.
module rv32i_instruction_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] instruction,
  output logic        done,
  output logic [5:0]  operation,
  output logic [4:0]  dest_reg,
  output logic [4:0]  src1_reg,
  output logic [4:0]  src2_reg,
  output logic [31:0] imm_value,
  output logic [1:0]  left_source,
  output logic        right_source,
  output logic        reads_src1,
  output logic        reads_src2,
  output logic        writes_dest,
  output logic [2:0]  insn_class
);

  // Input stage: the accepted word and a flag that marks it as a live item.
  logic                              in_valid;
  logic [rvdec_pkg::WordWidth-1:0]   in_word;

  // Decoded form of the word in the input stage, and the registered result.
  rvdec_pkg::decode_t                dec;
  rvdec_pkg::decode_t                result;

  // The pipeline never stalls, so the block is always ready for the next word.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word <= instruction;
    end
  end

  rvdec_decode u_decode (
    .instruction (in_word),
    .dec         (dec)
  );

  // Result stage: done marks a result for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result <= dec;
    end
  end

  assign operation    = result.operation;
  assign dest_reg     = result.dest_reg;
  assign src1_reg     = result.src1_reg;
  assign src2_reg     = result.src2_reg;
  assign imm_value    = result.imm_value;
  assign left_source  = result.left_source;
  assign right_source = result.right_source;
  assign reads_src1   = result.reads_src1;
  assign reads_src2   = result.reads_src2;
  assign writes_dest  = result.writes_dest;
  assign insn_class   = result.insn_class;

`ifndef SYNTHESIS
  // Every accepted item yields a result once it has passed the input and result registers.
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted item produced no result");

  // A result never appears without an accepted item having reached the input stage first.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("result strobe without an accepted item");

  // INVALID and HALT results carry no other information.
  a_empty_codes: assert property (@(posedge clk) disable iff (rst)
    (done && (operation == rvdec_pkg::OP_INVALID || operation == rvdec_pkg::OP_HALT)) |->
    (dest_reg == '0 && src1_reg == '0 && src2_reg == '0 && imm_value == '0 &&
     left_source == rvdec_pkg::SRC_REG && !right_source && !reads_src1 &&
     !reads_src2 && !writes_dest && insn_class == rvdec_pkg::CLS_OTHER))
    else $error("invalid or halt result with nonzero fields");

  // A register write is only flagged for a nonzero destination.
  a_write_dest: assert property (@(posedge clk) disable iff (rst)
    (done && writes_dest) |-> (dest_reg != '0))
    else $error("write flagged for register zero");

  // Stores and branches name no destination and read both sources.
  a_store_branch: assert property (@(posedge clk) disable iff (rst)
    (done && (insn_class == rvdec_pkg::CLS_STORE || insn_class == rvdec_pkg::CLS_BRANCH)) |->
    (dest_reg == '0 && !writes_dest && reads_src1 && reads_src2))
    else $error("store or branch result with inconsistent register use");
`endif

endmodule

/* verif/decode_checker.sv */
// Decode checker: predicts the decoded form of each accepted instruction word and compares results.
module decode_checker
  import rvdec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] instruction,
  input  logic        done,
  input  logic [5:0]  operation,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src1_reg,
  input  logic [4:0]  src2_reg,
  input  logic [31:0] imm_value,
  input  logic [1:0]  left_source,
  input  logic        right_source,
  input  logic        reads_src1,
  input  logic        reads_src2,
  input  logic        writes_dest,
  input  logic [2:0]  insn_class,
  output int          error_count,
  output int          pending
);

  localparam logic [OpWidth-1:0] REG_OPS [0:7] = '{
    OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND};
  localparam logic [OpWidth-1:0] IMM_OPS [0:7] = '{
    OP_ADDI, OP_INVALID, OP_SLTI, OP_SLTIU, OP_XORI, OP_INVALID, OP_ORI, OP_ANDI};
  localparam logic [OpWidth-1:0] LOAD_OPS [0:7] = '{
    OP_LB, OP_LH, OP_LW, OP_INVALID, OP_LBU, OP_LHU, OP_INVALID, OP_INVALID};
  localparam logic [OpWidth-1:0] STORE_OPS [0:7] = '{
    OP_SB, OP_SH, OP_SW, OP_INVALID, OP_INVALID, OP_INVALID, OP_INVALID, OP_INVALID};
  localparam logic [OpWidth-1:0] BRANCH_OPS [0:7] = '{
    OP_BEQ, OP_BNE, OP_INVALID, OP_INVALID, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU};

  decode_t expected_decodes[$];

  function automatic decode_t decode_word(input logic [31:0] w);
    decode_t     d;
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    rd    = w[11:7];
    rs1   = w[19:15];
    rs2   = w[24:20];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    d = '0;
    if (w == HALT_WORD) begin
      d.operation = OP_HALT;
    end else begin
      case (opc)
        OPC_OP: begin
          if (f7 == F7_BASE) d.operation = REG_OPS[f3];
          else if (f7 == F7_ALT && f3 == F3_ZERO) d.operation = OP_SUB;
          else if (f7 == F7_ALT && f3 == F3_SR) d.operation = OP_SRA;
          if (d.operation != OP_INVALID) begin
            d.dest_reg   = rd;
            d.src1_reg   = rs1;
            d.src2_reg   = rs2;
            d.reads_src1 = 1'b1;
            d.reads_src2 = 1'b1;
          end
        end
        OPC_OPIMM: begin
          if (f3 == F3_SL) begin
            if (f7 == F7_BASE) d.operation = OP_SLLI;
          end else if (f3 == F3_SR) begin
            if (f7 == F7_BASE) d.operation = OP_SRLI;
            else if (f7 == F7_ALT) d.operation = OP_SRAI;
          end else begin
            d.operation = IMM_OPS[f3];
          end
          if (d.operation != OP_INVALID) begin
            d.dest_reg     = rd;
            d.src1_reg     = rs1;
            // Shifts carry the shift amount, zero-extended, instead of the I immediate.
            d.imm_value    = (f3 == F3_SL || f3 == F3_SR) ? {27'b0, rs2} : imm_i;
            d.right_source = 1'b1;
            d.reads_src1   = 1'b1;
          end
        end
        OPC_LOAD: begin
          d.operation = LOAD_OPS[f3];
          if (d.operation != OP_INVALID) begin
            d.dest_reg     = rd;
            d.src1_reg     = rs1;
            d.imm_value    = imm_i;
            d.right_source = 1'b1;
            d.reads_src1   = 1'b1;
            d.insn_class   = CLS_LOAD;
          end
        end
        OPC_JALR: begin
          if (f3 == F3_ZERO) begin
            d.operation    = OP_JALR;
            d.dest_reg     = rd;
            d.src1_reg     = rs1;
            d.imm_value    = imm_i;
            d.right_source = 1'b1;
            d.reads_src1   = 1'b1;
            d.insn_class   = CLS_JUMP;
          end
        end
        OPC_STORE: begin
          d.operation = STORE_OPS[f3];
          if (d.operation != OP_INVALID) begin
            d.src1_reg     = rs1;
            d.src2_reg     = rs2;
            d.imm_value    = imm_s;
            d.right_source = 1'b1;
            d.reads_src1   = 1'b1;
            d.reads_src2   = 1'b1;
            d.insn_class   = CLS_STORE;
          end
        end
        OPC_BRANCH: begin
          d.operation = BRANCH_OPS[f3];
          if (d.operation != OP_INVALID) begin
            d.src1_reg   = rs1;
            d.src2_reg   = rs2;
            d.imm_value  = imm_b;
            d.reads_src1 = 1'b1;
            d.reads_src2 = 1'b1;
            d.insn_class = CLS_BRANCH;
          end
        end
        OPC_JAL: begin
          d.operation    = OP_JAL;
          d.dest_reg     = rd;
          d.imm_value    = imm_j;
          d.left_source  = SRC_PC;
          d.right_source = 1'b1;
          d.insn_class   = CLS_JUMP;
        end
        OPC_LUI, OPC_AUIPC: begin
          d.operation    = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
          d.dest_reg     = rd;
          d.imm_value    = w & UPPER_MASK;
          d.left_source  = (opc == OPC_LUI) ? SRC_ZERO : SRC_PC;
          d.right_source = 1'b1;
        end
        default: ;
      endcase
    end
    d.writes_dest = (d.operation != OP_INVALID && d.operation != OP_HALT && d.dest_reg != '0);
    return d;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: field %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    decode_t want;
    if (rst) begin
      error_count = 0;
      pending     <= 0;
    end else begin
      if (start && !busy) expected_decodes.push_back(decode_word(instruction));
      if (done) begin
        if (expected_decodes.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result arrived with no instruction outstanding", $realtime);
        end else begin
          want = expected_decodes.pop_front();
          check_field("operation",    32'(want.operation),    32'(operation));
          check_field("dest_reg",     32'(want.dest_reg),     32'(dest_reg));
          check_field("src1_reg",     32'(want.src1_reg),     32'(src1_reg));
          check_field("src2_reg",     32'(want.src2_reg),     32'(src2_reg));
          check_field("imm_value",    want.imm_value,         imm_value);
          check_field("left_source",  32'(want.left_source),  32'(left_source));
          check_field("right_source", 32'(want.right_source), 32'(right_source));
          check_field("reads_src1",   32'(want.reads_src1),   32'(reads_src1));
          check_field("reads_src2",   32'(want.reads_src2),   32'(reads_src2));
          check_field("writes_dest",  32'(want.writes_dest),  32'(writes_dest));
          check_field("insn_class",   32'(want.insn_class),   32'(insn_class));
        end
      end
      pending <= expected_decodes.size();
    end
  end

endmodule

/* verif/testbench.sv */
// Top of the decoder testbench: clock, reset, instruction stimulus and the final verdict.
module testbench;
  import rvdec_pkg::*;

  // Funct3 values used by the directed words that the package does not name.
  localparam logic [2:0] F3_WORD = 3'd2;  // LW, SW, SLT; undefined for branches
  localparam logic [2:0] F3_HOLE = 3'd3;  // undefined for loads and stores
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam int RandomItems = 1900;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [31:0] instruction = '0;
  logic        busy;
  logic        done;
  logic [5:0]  operation;
  logic [4:0]  dest_reg;
  logic [4:0]  src1_reg;
  logic [4:0]  src2_reg;
  logic [31:0] imm_value;
  logic [1:0]  left_source;
  logic        right_source;
  logic        reads_src1;
  logic        reads_src2;
  logic        writes_dest;
  logic [2:0]  insn_class;
  int          error_count;
  int          pending;

  always #6 clk = ~clk;

  rv32i_instruction_decoder u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .instruction(instruction),
    .done(done), .operation(operation), .dest_reg(dest_reg), .src1_reg(src1_reg),
    .src2_reg(src2_reg), .imm_value(imm_value), .left_source(left_source),
    .right_source(right_source), .reads_src1(reads_src1), .reads_src2(reads_src2),
    .writes_dest(writes_dest), .insn_class(insn_class)
  );

  // The checker watches both channels, predicts every decode and counts mismatches.
  decode_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .instruction(instruction),
    .done(done), .operation(operation), .dest_reg(dest_reg), .src1_reg(src1_reg),
    .src2_reg(src2_reg), .imm_value(imm_value), .left_source(left_source),
    .right_source(right_source), .reads_src1(reads_src1), .reads_src2(reads_src2),
    .writes_dest(writes_dest), .insn_class(insn_class),
    .error_count(error_count), .pending(pending)
  );

  function automatic logic [31:0] enc(input logic [6:0] f7, input logic [4:0] rs2,
                                      input logic [4:0] rs1, input logic [2:0] f3,
                                      input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  // Most random words are well formed with random content; a tenth are pure noise so
  // that every bit of the word takes both values, and a few sit on or next to the halt
  // word. The funct3 is always random, so undefined loads, stores and branches show up.
  function automatic logic [31:0] random_word();
    logic [6:0] opcodes [0:8];
    logic [6:0] opc;
    logic [6:0] f7;
    logic [2:0] f3;
    logic [4:0] rd;
    int         pick;
    opcodes = '{OPC_OP, OPC_OPIMM, OPC_LOAD, OPC_JALR, OPC_STORE, OPC_BRANCH,
                OPC_JAL, OPC_LUI, OPC_AUIPC};
    pick = $urandom_range(0, 99);
    if (pick < 10) return $urandom();
    if (pick < 13) return HALT_WORD ^ (32'h1 << $urandom_range(0, 31));
    if (pick < 14) return HALT_WORD;
    opc = opcodes[$urandom_range(0, 8)];
    f3  = 3'($urandom_range(0, 7));
    rd  = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom());
    f7  = 7'($urandom());
    // Where funct7 selects the operation, favor the two legal values.
    if (opc == OPC_OP || (opc == OPC_OPIMM && (f3 == F3_SL || f3 == F3_SR))) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) f7 = F7_BASE;
      else if (pick < 9) f7 = F7_ALT;
    end
    return enc(f7, 5'($urandom()), 5'($urandom()), f3, rd, opc);
  endfunction

  // Present one word and hold it until the block takes it, then idle for the given
  // number of cycles. With no idle cycles start simply stays high for the next item.
  task automatic send_word(input logic [31:0] word, input int idle_cycles);
    start       <= 1'b1;
    instruction <= word;
    do @(posedge clk); while (busy);
    if (idle_cycles > 0) begin
      start       <= 1'b0;
      instruction <= $urandom();
      repeat (idle_cycles) @(posedge clk);
    end
  endtask

  // Lower start and wait until every outstanding decode has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [31:0] directed_words[$];
    bit          burst;
    int          gap;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the halt word and its neighbor, all-zero and all-one words, every
    // format with immediate extremes, register zero as destination, and an undefined
    // funct3 or funct7 for each format that has one.
    directed_words = '{
      HALT_WORD,
      HALT_WORD ^ 32'h0000_0080,
      32'h0000_0000,
      32'hffff_ffff,
      enc(F7_BASE, 5'd31, 5'd31, F3_ZERO, 5'd31, OPC_OP),
      enc(F7_ALT, 5'd5, 5'd6, F3_ZERO, 5'd0, OPC_OP),
      enc(F7_ALT, 5'd1, 5'd2, F3_SR, 5'd3, OPC_OP),
      enc(7'h01, 5'd1, 5'd2, F3_ZERO, 5'd3, OPC_OP),
      enc(7'h40, 5'd0, 5'd1, F3_ZERO, 5'd0, OPC_OPIMM),
      enc(7'h3f, 5'd31, 5'd1, F3_ZERO, 5'd2, OPC_OPIMM),
      enc(F7_ALT, 5'd31, 5'd4, F3_SR, 5'd5, OPC_OPIMM),
      enc(F7_ALT, 5'd3, 5'd4, F3_SL, 5'd5, OPC_OPIMM),
      enc(7'h7f, 5'd31, 5'd8, F3_WORD, 5'd9, OPC_LOAD),
      enc(F7_BASE, 5'd0, 5'd8, F3_HOLE, 5'd9, OPC_LOAD),
      enc(F7_BASE, 5'd0, 5'd1, F3_SL, 5'd1, OPC_JALR),
      enc(7'h55, 5'd10, 5'd31, F3_ZERO, 5'd31, OPC_JALR),
      enc(7'h40, 5'd31, 5'd1, F3_WORD, 5'd0, OPC_STORE),
      enc(F7_BASE, 5'd2, 5'd1, F3_HOLE, 5'd5, OPC_STORE),
      enc(7'h7f, 5'd31, 5'd31, F3_BGEU, 5'd31, OPC_BRANCH),
      enc(F7_BASE, 5'd1, 5'd1, F3_WORD, 5'd0, OPC_BRANCH),
      32'h8000_00ef,
      32'h7fff_f06f,
      32'hffff_f0b7,
      32'h0000_0017,
      32'h1234_5097
    };
    foreach (directed_words[i]) send_word(directed_words[i], $urandom_range(0, 2));

    // Hold off once until the pipeline is empty before the random part.
    drain();

    burst = 1'b0;
    for (int i = 0; i < RandomItems; i++) begin
      // Every 40 items choose between back-to-back issue and random gaps.
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 16);
      send_word(random_word(), gap);
      if (i == RandomItems / 2) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // Worst case is about 1900 items at the largest random gap, well under a million
  // time units; this limit only trips on a hang.
  initial begin
    #5000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

/* files.f */
rtl/core/rvdec_pkg.sv
rtl/core/rvdec_decode.sv
rtl/core/rv32i_instruction_decoder.sv
verif/decode_checker.sv
verif/testbench.sv
